// File: design/rmat_pkg.sv
// ----------------------------------------------------------------------------
// rmat_pkg
// Shared types and constants of the R-MAT edge generator.
// ----------------------------------------------------------------------------
package rmat_pkg;

    // field widths
    localparam int VTX_W  = 30;
    localparam int THR_W  = 54;
    localparam int LVL_CW = 5;
    localparam int SEED_W = 64;
    localparam int FRAC_W = 53;

    // configuration port
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_SEED    = 3'd0;
    localparam logic [2:0] REG_LEVELS  = 3'd1;
    localparam logic [2:0] REG_THR_A   = 3'd2;
    localparam logic [2:0] REG_THR_AB  = 3'd3;
    localparam logic [2:0] REG_THR_ABC = 3'd4;

    // generator mixing constant and register reset values
    localparam logic [SEED_W-1:0] SEED_MIX    = 64'hdeadbeefcafe1234;
    localparam logic [LVL_CW-1:0] LEVELS_RST  = 5'd20;
    localparam logic [THR_W-1:0]  THR_A_RST   = 54'd5134103575202366;
    localparam logic [THR_W-1:0]  THR_AB_RST  = 54'd6845471433603154;
    localparam logic [THR_W-1:0]  THR_ABC_RST = 54'd8556839292003943;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic [LVL_CW-1:0] levels;
        logic [THR_W-1:0]  thr_a;
        logic [THR_W-1:0]  thr_ab;
        logic [THR_W-1:0]  thr_abc;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic start;      // item taken: load level count, clear coordinates
        logic load_seed;  // reload generator from seed
        logic draw;       // one level: draw and update coordinates
        logic emit;       // hand the finished pair to the output stage
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic lvl_zero;   // no levels left
        logic self_loop;  // row equals column
        logic out_busy;   // output stage still holds a pair
    } dp_sts_t;

    // one xorshift64 step (13, 7, 17)
    function automatic logic [SEED_W-1:0] xorshift64(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

endpackage

// File: design/rmat_edge_generator.sv
// ----------------------------------------------------------------------------
// rmat_edge_generator
// R-MAT edge generator driven by a 64-bit xorshift generator.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_ channel is one trial; s_tdata[0] set reloads the
//   generator from seed XOR a fixed constant before the trial.
//   The trial walks the configured number of levels (clamped to MAX_LEVELS),
//   one xorshift draw and quadrant decision per cycle. A trial takes the
//   item, draws once per level and then finishes; the serial chain of
//   generator draws sets how long it runs.
//   A trial that lands on the diagonal gives nothing; otherwise two items
//   leave on the m_ channel, (src,dst) and then (dst,src) with m_tlast high.
//   The pair sits in an output stage, so the next trial runs while it
//   drains; a trial finishing with the stage still full waits there.
//   A stalled receiver thus holds the block after at most one more off-diagonal trial.
//   Reset loads the register defaults, empties the output stage and sets the generator
//   state to the constant (seed zero). Registers sit on the APB port at byte address
//   8*index; the user must write them only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module rmat_edge_generator
    import rmat_pkg::*;
#(
    parameter int MAX_LEVELS = 30
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // trial requests
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] reseed, [7:1] zero
    // edges
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // [29:0] src_vertex, [59:30] dst_vertex, [63:60] zero
    output logic              m_tlast
);

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    rmat_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rmat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .reseed   (s_tdata[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    rmat_dpath #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: design/rmat_regs.sv
// ----------------------------------------------------------------------------
// rmat_regs
// APB register file: seed, level count and the three quadrant thresholds.
// ----------------------------------------------------------------------------
module rmat_regs
    import rmat_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[5:3];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seed    <= '0;
            cfg_reg.levels  <= LEVELS_RST;
            cfg_reg.thr_a   <= THR_A_RST;
            cfg_reg.thr_ab  <= THR_AB_RST;
            cfg_reg.thr_abc <= THR_ABC_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SEED:    cfg_reg.seed    <= pwdata;
                REG_LEVELS:  cfg_reg.levels  <= pwdata[LVL_CW-1:0];
                REG_THR_A:   cfg_reg.thr_a   <= pwdata[THR_W-1:0];
                REG_THR_AB:  cfg_reg.thr_ab  <= pwdata[THR_W-1:0];
                REG_THR_ABC: cfg_reg.thr_abc <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_SEED:    prdata = cfg_reg.seed;
            REG_LEVELS:  prdata = APB_DW'(cfg_reg.levels);
            REG_THR_A:   prdata = APB_DW'(cfg_reg.thr_a);
            REG_THR_AB:  prdata = APB_DW'(cfg_reg.thr_ab);
            REG_THR_ABC: prdata = APB_DW'(cfg_reg.thr_abc);
            default:     prdata = '0;
        endcase
    end

endmodule

// File: design/rmat_dpath.sv
// ----------------------------------------------------------------------------
// rmat_dpath
// Generator state, level counter, row/column accumulation and output stage.
// ----------------------------------------------------------------------------
module rmat_dpath
    import rmat_pkg::*;
#(
    parameter int MAX_LEVELS = 30
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,  // [29:0] src_vertex, [59:30] dst_vertex, [63:60] zero
    output logic               m_tlast
);

    localparam int LVL_W = $clog2(MAX_LEVELS + 1);

    logic [SEED_W-1:0] prng_reg, prng_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [VTX_W-1:0]  u_reg, u_next, v_reg, v_next;

    logic [SEED_W-1:0] draw_x;
    logic [FRAC_W-1:0] frac;
    logic              lt_a, lt_ab, lt_abc;
    logic [LVL_W-1:0]  bit_idx;
    logic [VTX_W:0]    step_w;
    logic [VTX_W-1:0]  step;
    logic [LVL_W-1:0]  lvl_init;

    logic              out_valid_reg, out_phase_reg;
    logic [VTX_W-1:0]  out_u_reg, out_v_reg;

    // level count clamped to the configured maximum
    always_comb begin
        if ({1'b0, cfg.levels} > (LVL_CW + 1)'(MAX_LEVELS)) begin
            lvl_init = LVL_W'(MAX_LEVELS);
        end else begin
            lvl_init = LVL_W'(cfg.levels);
        end
    end

    // one draw: next state, 53-bit fraction, quadrant tests
    assign draw_x  = xorshift64(prng_reg);
    assign frac    = draw_x[SEED_W-1:SEED_W-FRAC_W];
    assign lt_a    = {1'b0, frac} < cfg.thr_a;
    assign lt_ab   = {1'b0, frac} < cfg.thr_ab;
    assign lt_abc  = {1'b0, frac} < cfg.thr_abc;
    assign bit_idx = lvl_reg - LVL_W'(1);
    assign step_w  = (VTX_W + 1)'(1) << bit_idx;
    assign step    = step_w[VTX_W-1:0];  // bit VTX_W of the shifted one is dropped to fit the vertex range

    // next-state logic
    always_comb begin
        prng_next = prng_reg;
        lvl_next  = lvl_reg;
        u_next    = u_reg;
        v_next    = v_reg;
        if (cmd.load_seed) begin
            prng_next = cfg.seed ^ SEED_MIX;
        end
        if (cmd.start) begin
            lvl_next = lvl_init;
            u_next   = '0;
            v_next   = '0;
        end
        if (cmd.draw) begin
            prng_next = draw_x;
            lvl_next  = lvl_reg - LVL_W'(1);
            if (lt_a) begin
                // quadrant a: no move
            end else if (lt_ab) begin
                v_next = v_reg | step;
            end else if (lt_abc) begin
                u_next = u_reg | step;
            end else begin
                u_next = u_reg | step;
                v_next = v_reg | step;
            end
        end
    end

    // generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prng_reg <= SEED_MIX;
        end else begin
            prng_reg <= prng_next;
        end
    end

    // level counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg <= '0;
        end else begin
            lvl_reg <= lvl_next;
        end
    end

    // coordinates
    always_ff @(posedge aclk) begin
        u_reg <= u_next;
        v_reg <= v_next;
    end

    // output stage: holds one pair, sends (u,v) then (v,u)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_phase_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
            out_phase_reg <= 1'b0;
        end else if (out_valid_reg && m_tready) begin
            if (out_phase_reg) begin
                out_valid_reg <= 1'b0;
            end
            out_phase_reg <= ~out_phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_u_reg <= u_reg;
            out_v_reg <= v_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_phase_reg;
    assign m_tdata  = out_phase_reg ? {4'b0, out_u_reg, out_v_reg}
                                    : {4'b0, out_v_reg, out_u_reg};

    assign sts.lvl_zero  = (lvl_reg == '0);
    assign sts.self_loop = (u_reg == v_reg);
    assign sts.out_busy  = out_valid_reg;

    // a pair never overwrites one still in the output stage
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !out_valid_reg)
        else $error("pair loaded while output stage busy");

    // draws stop when the level count is spent
    a_draw_lvl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw |-> lvl_reg != '0)
        else $error("draw with no levels left");

    // self-loops never reach the output
    a_no_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_u_reg != out_v_reg)
        else $error("self-loop in output stage");

    // the stage empties right after the mirrored edge is taken
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_phase_reg && m_tready) |=> !out_valid_reg)
        else $error("output stage did not drain after last edge");

endmodule

// File: design/rmat_ctrl.sv
// ----------------------------------------------------------------------------
// rmat_ctrl
// Trial sequencer: takes an item, runs the level draws, hands off the pair or drops a self-loop.
// ----------------------------------------------------------------------------
module rmat_ctrl
    import rmat_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    reseed,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DRAW = 1'b1;

    logic state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // sequencing
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start     = 1'b1;
                    cmd.load_seed = reseed;
                    state_next    = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (!sts.lvl_zero) begin
                    cmd.draw = 1'b1;
                end else if (sts.self_loop) begin
                    state_next = ST_IDLE;
                end else if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a pair is handed off only after every level has been drawn
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (sts.lvl_zero && !sts.self_loop))
        else $error("pair handed off before the trial finished");

    // no new item while a trial is still drawing
    a_one_trial: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw |-> !s_tready)
        else $error("input ready during draws");

    // the seed reload happens only with an accepted item
    a_seed_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_seed |-> cmd.start)
        else $error("seed reload outside item acceptance");

endmodule
